>>> rtl/l2_multicast_group_table_core_macros.svh
// Assertion macros for the multicast group table RTL (used by l2mg_dp).
// Needs nothing else; each file that asserts includes it.
`ifndef L2_MULTICAST_GROUP_TABLE_CORE_MACROS_SVH
`define L2_MULTICAST_GROUP_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define L2MG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define L2MG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/l2mg_pkg.sv
// Types and constants of the multicast group table.
// Used by l2mg_ctrl, l2mg_dp and the top level; depends on nothing.
package l2mg_pkg;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_SET    = 2'd2;
  localparam logic [1:0] FUNC_GET    = 2'd3;

  // Upper 24 bits of an IPv4 multicast MAC (01:00:5e).
  localparam logic [23:0] MAC_OUI = 24'h01005e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_SHIFT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] grp;
    logic [11:0] vlan;
    logic [11:0] vidx;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture the accepted item, restart the scan
    logic scan_en;    // walk the table looking for the first match
    logic exec;       // apply insert / set, latch the result
    logic shift_en;   // close the gap left by a removed entry
    logic shift_end;  // drop the entry count after the shift
    logic finish;     // move the result into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;
    logic shift_done;
    logic hit;
    logic is_remove;
  } sts_t;

endpackage

>>> rtl/l2mg_ctrl.sv
// Sequencer of the multicast group table: scan, update, shift and result handoff.
// Depends on l2mg_pkg; drives the datapath l2mg_dp through cmd_t / sts_t.
module l2mg_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  l2mg_pkg::sts_t sts,
  output l2mg_pkg::cmd_t cmd
);
  import l2mg_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:  if (sts.scan_done) state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = (sts.is_remove && sts.hit) ? ST_SHIFT : ST_DONE;
      ST_SHIFT: if (sts.shift_done) state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:  cmd.load = in_valid;
      ST_SCAN:  cmd.scan_en = 1'b1;
      ST_EXEC:  cmd.exec = 1'b1;
      ST_SHIFT: begin
        cmd.shift_en  = 1'b1;
        cmd.shift_end = sts.shift_done;
      end
      ST_DONE:  cmd.finish = out_free;
      default:  cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.finish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/l2mg_dp.sv
// Datapath of the multicast group table: entry memory, scan pointer, match
// logic, entry count and result registers. Depends on l2mg_pkg and the macros.
`include "l2_multicast_group_table_core_macros.svh"

module l2mg_dp #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     in_func,
  input  logic [31:0]    in_group_addr,
  input  logic [11:0]    in_vlan_id,
  input  logic [47:0]    in_group_mac,
  input  logic [11:0]    in_vidx,
  input  l2mg_pkg::cmd_t cmd,
  output l2mg_pkg::sts_t sts,
  output logic           out_status,
  output logic [11:0]    out_vidx_out
);
  import l2mg_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

  entry_t mem [TABLE_ENTRIES];

  // item under work
  logic [1:0]  func_r;
  logic [31:0] grp_r;
  logic [11:0] vlan_r;
  logic [47:0] mac_r;
  logic [11:0] vidx_r;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] rd_idx_r;
  logic          rd_vld_r, rd_vld_nxt;
  entry_t        rd_data_r;
  logic          hit_r;
  logic [CW-1:0] hit_idx_r;
  entry_t        hit_ent_r;
  logic          res_status_r;
  logic [11:0]   res_vidx_r;
  logic          out_status_r;
  logic [11:0]   out_vidx_r;

  logic          key_hit, mac_hit, by_mac, match_now;
  logic          rd_en, ins_ok;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic [CW-1:0] wr_pos;

  assign key_hit = (rd_data_r.grp == grp_r) && (rd_data_r.vlan == vlan_r);
  assign mac_hit = (rd_data_r.vlan == vlan_r) &&
                   (mac_r == {MAC_OUI, 1'b0, rd_data_r.grp[22:0]});
  assign by_mac  = (func_r == FUNC_SET) || (func_r == FUNC_GET);
  assign match_now = cmd.scan_en && rd_vld_r && !hit_r && (by_mac ? mac_hit : key_hit);

  // stop issuing reads once the first match is seen
  assign rd_en = (cmd.scan_en && !hit_r && !match_now && (idx_r < count_r)) ||
                 (cmd.shift_en && (idx_r < count_r));

  assign ins_ok = (func_r == FUNC_INSERT) && !hit_r && (count_r < FULL);
  assign wr_pos = rd_idx_r - CW'(1);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data_r;
    if (cmd.exec && ins_ok) begin
      wr_en   = 1'b1;
      wr_addr = count_r[AW-1:0];
      wr_data = '{grp: grp_r, vlan: vlan_r, vidx: vidx_r};
    end else if (cmd.exec && (func_r == FUNC_SET) && hit_r) begin
      wr_en   = 1'b1;
      wr_addr = hit_idx_r[AW-1:0];
      wr_data = '{grp: hit_ent_r.grp, vlan: hit_ent_r.vlan, vidx: vidx_r};
    end else if (cmd.shift_en && rd_vld_r) begin
      // move entry down by one slot
      wr_en   = 1'b1;
      wr_addr = wr_pos[AW-1:0];
      wr_data = rd_data_r;
    end
  end

  always_comb begin
    idx_nxt    = idx_r;
    rd_vld_nxt = rd_en;
    if (cmd.load) begin
      idx_nxt    = '0;
      rd_vld_nxt = 1'b0;
    end else if (cmd.exec) begin
      idx_nxt    = hit_idx_r + CW'(1);
      rd_vld_nxt = 1'b0;
    end else if (rd_en) begin
      idx_nxt = idx_r + CW'(1);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.exec && ins_ok) count_nxt = count_r + CW'(1);
    else if (cmd.shift_end) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      rd_vld_r <= rd_vld_nxt;
      if (cmd.load) hit_r <= 1'b0;
      else if (match_now) hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      grp_r  <= in_group_addr;
      vlan_r <= in_vlan_id;
      mac_r  <= in_group_mac;
      vidx_r <= in_vidx;
    end
    if (rd_en) rd_idx_r <= idx_r;
    if (match_now) begin
      hit_idx_r <= rd_idx_r;
      hit_ent_r <= rd_data_r;
    end
    if (cmd.exec) begin
      res_status_r <= (func_r == FUNC_INSERT) && !hit_r && (count_r == FULL);
      res_vidx_r   <= ((func_r == FUNC_GET) && hit_r) ? hit_ent_r.vidx : 12'd0;
    end
    if (cmd.finish) begin
      out_status_r <= res_status_r;
      out_vidx_r   <= res_vidx_r;
    end
  end

  assign sts.scan_done  = !rd_vld_r && (hit_r || (idx_r >= count_r));
  assign sts.shift_done = !rd_vld_r && (idx_r >= count_r);
  assign sts.hit        = hit_r;
  assign sts.is_remove  = (func_r == FUNC_REMOVE);

  assign out_status   = out_status_r;
  assign out_vidx_out = out_vidx_r;

  `L2MG_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, count_r <= FULL, "entry count above table size")
  `L2MG_ASSERT_NOW(a_wr_in_use, clk, rst_n, wr_en, CW'(wr_addr) <= count_r, "write beyond packed entries")
  `L2MG_ASSERT_NOW(a_no_ins_full, clk, rst_n, cmd.exec && wr_en && (func_r == FUNC_INSERT), count_r < FULL, "insert into a full table")
  `L2MG_ASSERT_NEXT(a_remove_dec, clk, rst_n, cmd.shift_end, count_r == $past(count_r) - CW'(1), "remove did not drop the count")
  `L2MG_ASSERT_NEXT(a_hit_sticky, clk, rst_n, hit_r && !cmd.load, hit_r, "match flag lost before the next item")

endmodule

>>> rtl/l2_multicast_group_table_core.sv
// Channel  Ports                                              Direction
// in       in_valid/in_stall, in_func, in_group_addr,         item in
//          in_vlan_id, in_group_mac, in_vidx
// out      out_valid/out_stall, out_status, out_vidx_out      result out
//
// Scan: one entry is read per cycle, all count of them on a miss, and k + 1
// when slot k matches first. A remove hit in slot k then moves each later entry
// down one slot; nothing moves when k is the last entry. A new item is taken
// only after the last one has reached the output register.
// Reset: rst_n is synchronous; the table comes up empty with no clearing pass.
// Stalls: a result waits in the output register while the next item is taken;
// a finished item holds in its last step only while that register stays full.
module l2_multicast_group_table_core #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_group_addr,
  input  logic [11:0] in_vlan_id,
  input  logic [47:0] in_group_mac,
  input  logic [11:0] in_vidx,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [11:0] out_vidx_out
);
  import l2mg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  l2mg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  l2mg_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_func       (in_func),
    .in_group_addr (in_group_addr),
    .in_vlan_id    (in_vlan_id),
    .in_group_mac  (in_group_mac),
    .in_vidx       (in_vidx),
    .cmd           (cmd),
    .sts           (sts),
    .out_status    (out_status),
    .out_vidx_out  (out_vidx_out)
  );

endmodule

>>> test/tb.sv
// Testbench for l2_multicast_group_table_core: a queue-fed driver, a monitor and a
// table predictor that checks every result in order. Depends on l2mg_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import l2mg_pkg::*;

  localparam int TABLE_ENTRIES = 64;
  localparam int NKEY = 96;
  localparam int TARGET_ITEMS = 1925;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] grp;
    logic [11:0] vlan;
    logic [47:0] mac;
    logic [11:0] vidx;
  } mg_op_t;

  typedef struct packed {
    logic        status;
    logic [11:0] vidx;
  } mg_resp_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_func;
  logic [31:0] in_group_addr;
  logic [11:0] in_vlan_id;
  logic [47:0] in_group_mac;
  logic [11:0] in_vidx;
  logic        out_valid;
  logic        out_stall;
  logic        out_status;
  logic [11:0] out_vidx_out;

  l2_multicast_group_table_core #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_group_addr(in_group_addr), .in_vlan_id(in_vlan_id),
    .in_group_mac(in_group_mac), .in_vidx(in_vidx),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_vidx_out(out_vidx_out)
  );

  // Predicted table contents, packed in insertion order
  logic [31:0] tbl_grp  [TABLE_ENTRIES];
  logic [11:0] tbl_vlan [TABLE_ENTRIES];
  logic [11:0] tbl_vidx [TABLE_ENTRIES];
  int          tbl_count;

  mg_op_t   pending_ops[$];
  mg_resp_t expected_resp[$];
  int       mismatches;
  int       ops_pushed;

  int send_idle_pct;
  int recv_stall_pct;
  logic hold_go;
  logic hold_done;
  int   hold_cnt;
  logic in_fire;
  mg_op_t drv_op;

  logic [31:0] key_grp  [NKEY];
  logic [11:0] key_vlan [NKEY];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [47:0] mac_of(logic [31:0] g);
    return {MAC_OUI, 1'b0, g[22:0]};
  endfunction

  function automatic int find_by_key(logic [31:0] g, logic [11:0] v);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_grp[i] == g && tbl_vlan[i] == v) return i;
    return -1;
  endfunction

  function automatic int find_by_mac(logic [11:0] v, logic [47:0] m);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_vlan[i] == v && m == mac_of(tbl_grp[i])) return i;
    return -1;
  endfunction

  function automatic mg_resp_t apply_op(mg_op_t op);
    mg_resp_t r;
    int k;
    r = '0;
    case (op.func)
      FUNC_INSERT: begin
        if (find_by_key(op.grp, op.vlan) < 0) begin
          if (tbl_count >= TABLE_ENTRIES) begin
            r.status = 1'b1;
          end else begin
            tbl_grp[tbl_count]  = op.grp;
            tbl_vlan[tbl_count] = op.vlan;
            tbl_vidx[tbl_count] = op.vidx;
            tbl_count++;
          end
        end
      end
      FUNC_REMOVE: begin
        k = find_by_key(op.grp, op.vlan);
        if (k >= 0) begin
          // close the gap, keep order
          for (int i = k; i + 1 < tbl_count; i++) begin
            tbl_grp[i]  = tbl_grp[i + 1];
            tbl_vlan[i] = tbl_vlan[i + 1];
            tbl_vidx[i] = tbl_vidx[i + 1];
          end
          tbl_count--;
        end
      end
      FUNC_SET: begin
        k = find_by_mac(op.vlan, op.mac);
        if (k >= 0) tbl_vidx[k] = op.vidx;
      end
      FUNC_GET: begin
        k = find_by_mac(op.vlan, op.mac);
        if (k >= 0) r.vidx = tbl_vidx[k];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [47:0] rand_mac();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  task automatic push_op(logic [1:0] f, logic [31:0] g, logic [11:0] v,
                         logic [47:0] m, logic [11:0] x);
    mg_op_t op;
    op.func = f;
    op.grp  = g;
    op.vlan = v;
    op.mac  = m;
    op.vidx = x;
    pending_ops.push_back(op);
    ops_pushed++;
  endtask

  // One random operation, mostly on known keys so lookups hit
  task automatic gen_op();
    int r;
    int k;
    int sel;
    logic [11:0] v;
    logic [47:0] m;
    r = $urandom_range(99);
    k = $urandom_range(NKEY - 1);
    v = key_vlan[k];
    m = mac_of(key_grp[k]);
    sel = $urandom_range(9);
    if (sel == 0) m = m | 48'h00_0000_80_0000;
    else if (sel == 1) v = 12'($urandom());
    else if (sel == 2) m = m ^ (48'd1 << (24 + $urandom_range(23)));
    if (r < 25)
      push_op(FUNC_INSERT, key_grp[k], key_vlan[k], rand_mac(), 12'($urandom()));
    else if (r < 40)
      push_op(FUNC_REMOVE, key_grp[k], key_vlan[k], rand_mac(), 12'($urandom()));
    else if (r < 60)
      push_op(FUNC_SET, 32'($urandom()), v, m, 12'($urandom()));
    else if (r < 90)
      push_op(FUNC_GET, 32'($urandom()), v, m, 12'($urandom()));
    else
      push_op(2'($urandom()), 32'($urandom()), 12'($urandom()), rand_mac(),
              12'($urandom()));
  endtask

  // Insert a run of distinct keys, past the table size, then retry a few
  task automatic fill_burst();
    int k0;
    k0 = $urandom_range(NKEY - 1);
    for (int j = 0; j < 70; j++)
      push_op(FUNC_INSERT, key_grp[(k0 + j) % NKEY], key_vlan[(k0 + j) % NKEY],
              rand_mac(), 12'($urandom()));
    for (int j = 0; j < 3; j++)
      push_op(FUNC_INSERT, key_grp[(k0 + j) % NKEY], key_vlan[(k0 + j) % NKEY],
              rand_mac(), 12'($urandom()));
  endtask

  task automatic drain_burst();
    int k;
    for (int j = 0; j < 40; j++) begin
      k = $urandom_range(NKEY - 1);
      push_op(FUNC_REMOVE, key_grp[k], key_vlan[k], rand_mac(), 12'($urandom()));
    end
  endtask

  task automatic gen_batch(int n);
    int r;
    int stop_at;
    stop_at = ops_pushed + n;
    while (ops_pushed < stop_at) begin
      r = $urandom_range(99);
      if (r < 6) fill_burst();
      else if (r < 11) drain_burst();
      else gen_op();
    end
  endtask

  task automatic wait_sent();
    while (pending_ops.size() != 0) @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || in_valid || expected_resp.size() != 0)
      @(posedge clk);
  endtask

  // Driver: advance on a transfer or while idle, hold while stalled
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_op = pending_ops.pop_front();
        in_valid      <= 1'b1;
        in_func       <= drv_op.func;
        in_group_addr <= drv_op.grp;
        in_vlan_id    <= drv_op.vlan;
        in_group_mac  <= drv_op.mac;
        in_vidx       <= drv_op.vidx;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    mg_op_t op;
    if (rst_n && in_valid && !in_stall) begin
      op.func = in_func;
      op.grp  = in_group_addr;
      op.vlan = in_vlan_id;
      op.mac  = in_group_mac;
      op.vidx = in_vidx;
      expected_resp.push_back(apply_op(op));
      in_fire <= 1'b1;
    end else begin
      in_fire <= 1'b0;
    end
  end

  // Receiver stall, with one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt - 1;
    end else if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_cnt  <= 400;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    mg_resp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_resp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status=%0d vidx=%0h", out_status, out_vidx_out);
      end else begin
        want = expected_resp.pop_front();
        if (out_status !== want.status || out_vidx_out !== want.vidx) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status=%0d vidx=%0h, got status=%0d vidx=%0h",
                     want.status, want.vidx, out_status, out_vidx_out);
        end
      end
    end
  end

  initial begin
    int phase;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = '0;
    in_group_addr = '0;
    in_vlan_id = '0;
    in_group_mac = '0;
    in_vidx = '0;
    out_stall = 1'b0;
    in_fire = 1'b0;
    hold_go = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    ops_pushed = 0;
    tbl_count = 0;

    // Key pool: extremes, shared VLANs, and pairs that alias in the MAC
    for (int i = 0; i < NKEY; i++) begin
      case ($urandom_range(4))
        0: key_vlan[i] = 12'h000;
        1: key_vlan[i] = 12'hfff;
        2: key_vlan[i] = 12'h001;
        default: key_vlan[i] = 12'($urandom());
      endcase
      if (i % 8 == 7) begin
        key_grp[i]  = key_grp[i - 1] ^ {9'($urandom_range(1, 511)), 23'd0};
        key_vlan[i] = key_vlan[i - 1];
      end else begin
        key_grp[i] = $urandom();
      end
    end
    key_grp[0] = 32'h0000_0000;
    key_grp[1] = 32'hffff_ffff;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // Directed: extremes, duplicates, misses, head removal, aliasing groups
    push_op(FUNC_INSERT, 32'h0000_0000, 12'h000, 48'h0, 12'h000);
    push_op(FUNC_INSERT, 32'hffff_ffff, 12'hfff, 48'hffff_ffff_ffff, 12'hfff);
    push_op(FUNC_INSERT, 32'h0000_0000, 12'h000, 48'h0, 12'h5a5);
    push_op(FUNC_GET, 32'h0, 12'h000, mac_of(32'h0), 12'h0);
    push_op(FUNC_GET, 32'h0, 12'hfff, mac_of(32'hffff_ffff), 12'hfff);
    push_op(FUNC_GET, 32'h0, 12'hfff, 48'h0100_5eff_ffff, 12'h0);
    push_op(FUNC_GET, 32'h0, 12'h001, mac_of(32'h0), 12'h0);
    push_op(FUNC_SET, 32'h0, 12'hfff, mac_of(32'hffff_ffff), 12'h123);
    push_op(FUNC_GET, 32'h0, 12'hfff, mac_of(32'hffff_ffff), 12'h0);
    push_op(FUNC_SET, 32'hffff_ffff, 12'h002, mac_of(32'h0), 12'hfff);
    push_op(FUNC_REMOVE, 32'h1234_5678, 12'h000, 48'h0, 12'h0);
    push_op(FUNC_REMOVE, 32'h0000_0000, 12'h000, 48'h0, 12'h0);
    push_op(FUNC_GET, 32'h0, 12'h000, mac_of(32'h0), 12'h0);
    push_op(FUNC_GET, 32'h0, 12'hfff, mac_of(32'hffff_ffff), 12'h0);
    push_op(FUNC_INSERT, 32'he000_0001, 12'h010, 48'h0, 12'h0aa);
    push_op(FUNC_INSERT, 32'he080_0001, 12'h010, 48'h0, 12'h0bb);
    push_op(FUNC_GET, 32'h0, 12'h010, mac_of(32'he000_0001), 12'h0);
    push_op(FUNC_SET, 32'h0, 12'h010, mac_of(32'he080_0001), 12'h0cc);
    push_op(FUNC_GET, 32'h0, 12'h010, mac_of(32'he000_0001), 12'h0);
    push_op(FUNC_REMOVE, 32'he000_0001, 12'h010, 48'h0, 12'h0);
    push_op(FUNC_GET, 32'h0, 12'h010, mac_of(32'he080_0001), 12'h0);
    push_op(FUNC_GET, 32'h0, 12'h010, mac_of(32'he000_0001) | 48'h80_0000, 12'h0);
    push_op(FUNC_GET, 32'hffff_ffff, 12'hfff, 48'hffff_ffff_ffff, 12'hfff);
    wait_drained();

    // Start random part by filling past capacity, with duplicates in a full table
    fill_burst();
    phase = 0;
    while (ops_pushed < TARGET_ITEMS) begin
      @(posedge clk);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      if (phase == 4) hold_go = 1'b1;
      gen_batch(110);
      wait_sent();
      // pause the sender until every result is back
      if (phase % 3 == 2) wait_drained();
      phase++;
    end

    wait_drained();
    repeat (400) @(posedge clk);
    if (mismatches == 0 && expected_resp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
